[src/ultrasonic_echo_ranger_macros.svh]
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define UER_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("uer assertion failed");

// Checked on every clock edge, reset included.
`define UER_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("uer assertion failed");

`else

`define UER_ASSERT(label, clk, rst, prop)
`define UER_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[src/uer_pkg.sv]
// Shared types and constants of the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

   // Counter width of the elapsed and width counters.
   localparam int CountBitsDefault = 16;

   // Configuration port geometry.
   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;
   localparam int RegIdxBits  = 3;

   // Register indexes.
   localparam logic [RegIdxBits-1:0] RegEchoTimeout  = 3'd0;
   localparam logic [RegIdxBits-1:0] RegTrigLow      = 3'd1;
   localparam logic [RegIdxBits-1:0] RegTrigHigh     = 3'd2;
   localparam logic [RegIdxBits-1:0] RegActiveLevel  = 3'd3;
   localparam logic [RegIdxBits-1:0] RegDistScale    = 3'd4;

   // Reset values of the registers.
   localparam logic [15:0] EchoTimeoutReset = 16'd10000;
   localparam logic [7:0]  TrigLowReset     = 8'd2;
   localparam logic [7:0]  TrigHighReset    = 8'd10;
   localparam logic        ActiveLevelReset = 1'b1;
   localparam logic [15:0] DistScaleReset   = 16'd1124;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   typedef struct packed {
      logic [15:0] echo_timeout;
      logic [7:0]  trig_low;
      logic [7:0]  trig_high;
      logic        active_level;
      logic [15:0] dist_scale;
   } cfg_type;

   typedef struct packed {
      logic        trigger_level;
      logic        busy;
      logic        done;
      logic        timed_out;
      logic [15:0] pulse_width;
      logic [15:0] distance;
   } result_type;

endpackage

`default_nettype wire

[src/uer_csr.sv]
// Configuration register file of the ultrasonic echo ranger.
`default_nettype none

module uer_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [uer_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  wire logic [uer_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic      [uer_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output uer_pkg::cfg_type                       cfg
);

   uer_pkg::cfg_type                 cfg_ff;
   uer_pkg::cfg_type                 cfg_in;
   logic [uer_pkg::RegIdxBits-1:0]   reg_idx;
   logic                             wr_en;

   assign reg_idx    = csr_paddr[uer_pkg::CsrAddrBits-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            uer_pkg::RegEchoTimeout: cfg_in.echo_timeout = csr_pwdata[15:0];
            uer_pkg::RegTrigLow:     cfg_in.trig_low     = csr_pwdata[7:0];
            uer_pkg::RegTrigHigh:    cfg_in.trig_high    = csr_pwdata[7:0];
            uer_pkg::RegActiveLevel: cfg_in.active_level = csr_pwdata[0];
            uer_pkg::RegDistScale:   cfg_in.dist_scale   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         uer_pkg::RegEchoTimeout: csr_prdata = 32'(cfg_ff.echo_timeout);
         uer_pkg::RegTrigLow:     csr_prdata = 32'(cfg_ff.trig_low);
         uer_pkg::RegTrigHigh:    csr_prdata = 32'(cfg_ff.trig_high);
         uer_pkg::RegActiveLevel: csr_prdata = 32'(cfg_ff.active_level);
         uer_pkg::RegDistScale:   csr_prdata = 32'(cfg_ff.dist_scale);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_timeout <= uer_pkg::EchoTimeoutReset;
         cfg_ff.trig_low     <= uer_pkg::TrigLowReset;
         cfg_ff.trig_high    <= uer_pkg::TrigHighReset;
         cfg_ff.active_level <= uer_pkg::ActiveLevelReset;
         cfg_ff.dist_scale   <= uer_pkg::DistScaleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[src/uer_core.sv]
// Measurement sequencer: trigger timing, echo wait, width count and distance.
`default_nettype none

module uer_core #(
   parameter int COUNT_BITS = uer_pkg::CountBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic                 start_req,
   input  wire logic                 echo_level,
   input  wire uer_pkg::cfg_type     cfg,
   output uer_pkg::result_type       result
);

   localparam int LimW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
   localparam logic [LimW-1:0]       CountMaxWide = LimW'(CountMax);

   uer_pkg::phase_type       phase_ff;
   uer_pkg::phase_type       phase_in;
   logic [7:0]               trig_cnt_ff;
   logic [7:0]               trig_cnt_in;
   logic [COUNT_BITS-1:0]    elapsed_ff;
   logic [COUNT_BITS-1:0]    elapsed_in;
   logic [COUNT_BITS-1:0]    width_ff;
   logic [COUNT_BITS-1:0]    width_in;

   logic [LimW-1:0]          timeout_wide;
   logic [COUNT_BITS-1:0]    limit;
   logic [COUNT_BITS-1:0]    elapsed_inc;
   logic [COUNT_BITS-1:0]    width_inc;
   logic                     echo_hit;
   logic                     limit_hit;
   logic                     done;
   logic                     timed_out;
   logic [COUNT_BITS-1:0]    width_sel;
   logic [15:0]              width16;
   logic [31:0]              product;

   // A timeout beyond the counter range saturates at the largest count.
   assign timeout_wide = LimW'(cfg.echo_timeout);
   assign limit = (timeout_wide > CountMaxWide) ? CountMax : timeout_wide[COUNT_BITS-1:0];

   assign elapsed_inc = (elapsed_ff == CountMax) ? elapsed_ff : elapsed_ff + CountOne;
   assign width_inc   = (width_ff == CountMax) ? width_ff : width_ff + CountOne;
   assign echo_hit    = (echo_level == cfg.active_level);
   assign limit_hit   = (elapsed_inc >= limit);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               phase_in = (cfg.trig_low != 8'd0) ? uer_pkg::PH_TRIG_LOW
                                                 : uer_pkg::PH_TRIG_HIGH;
            end
         end
         uer_pkg::PH_TRIG_LOW: begin
            if (trig_cnt_ff >= cfg.trig_low) begin
               phase_in = uer_pkg::PH_TRIG_HIGH;
            end
         end
         uer_pkg::PH_TRIG_HIGH: begin
            if (trig_cnt_ff >= cfg.trig_high) begin
               phase_in = uer_pkg::PH_WAIT;
            end
         end
         uer_pkg::PH_WAIT: begin
            if (echo_hit) begin
               phase_in = uer_pkg::PH_MEAS;
            end else if (limit_hit) begin
               phase_in = uer_pkg::PH_IDLE;
            end
         end
         uer_pkg::PH_MEAS: begin
            if (!echo_hit || limit_hit) begin
               phase_in = uer_pkg::PH_IDLE;
            end
         end
         default: phase_in = uer_pkg::PH_IDLE;
      endcase
   end

   // Counters and result flags.
   always_comb begin
      trig_cnt_in = trig_cnt_ff;
      elapsed_in  = elapsed_ff;
      width_in    = width_ff;
      done        = 1'b0;
      timed_out   = 1'b0;
      width_sel   = '0;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (start_req) begin
               trig_cnt_in = 8'd1;
            end
         end
         uer_pkg::PH_TRIG_LOW: begin
            trig_cnt_in = (trig_cnt_ff >= cfg.trig_low) ? 8'd1 : trig_cnt_ff + 8'd1;
         end
         uer_pkg::PH_TRIG_HIGH: begin
            if (trig_cnt_ff >= cfg.trig_high) begin
               trig_cnt_in = 8'd0;
               elapsed_in  = '0;
               width_in    = '0;
            end else begin
               trig_cnt_in = trig_cnt_ff + 8'd1;
            end
         end
         uer_pkg::PH_WAIT: begin
            elapsed_in = elapsed_inc;
            if (echo_hit) begin
               width_in = CountOne;
            end else if (limit_hit) begin
               done      = 1'b1;
               timed_out = 1'b1;
            end
         end
         uer_pkg::PH_MEAS: begin
            elapsed_in = elapsed_inc;
            if (!echo_hit) begin
               done      = 1'b1;
               width_sel = width_ff;
            end else if (limit_hit) begin
               done      = 1'b1;
               timed_out = 1'b1;
            end else begin
               width_in = width_inc;
            end
         end
         default: ;
      endcase
   end

   assign width16 = 16'(width_sel);
   assign product = 32'(width16) * 32'(cfg.dist_scale);

   always_comb begin
      result.trigger_level = (phase_in == uer_pkg::PH_TRIG_HIGH);
      result.busy          = (phase_in != uer_pkg::PH_IDLE);
      result.done          = done;
      result.timed_out     = timed_out;
      result.pulse_width   = width16;
      result.distance      = product[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= uer_pkg::PH_IDLE;
         trig_cnt_ff <= '0;
         elapsed_ff  <= '0;
         width_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         trig_cnt_ff <= trig_cnt_in;
         elapsed_ff  <= elapsed_in;
         width_ff    <= width_in;
      end
   end

endmodule

`default_nettype wire

[src/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: request/response channels and CSR port.
`default_nettype none

`include "ultrasonic_echo_ranger_macros.svh"

// Channel   Direction  Handshake              Contents
// req_      in         req_valid / req_ready  one microsecond tick: start, echo sample
// rsp_      out        rsp_valid / rsp_ready  trigger, busy, done, timeout, width, distance
// csr_      in/out     APB psel/penable       five configuration registers, 32-bit data
//
// Every request yields exactly one response, registered when it is accepted; unless
// a response stalls, a request can be accepted in every cycle: one tick per cycle.
// The sequencer state and the response register are the only storage in the tick path.
// When a response waits in the response register with rsp_ready low, req_ready drops
// in the same cycle and the sequencer holds. Reset is synchronous and clears the
// sequencer to idle, the response register to empty and the CSRs to their defaults.

module ultrasonic_echo_ranger #(
   parameter int COUNT_BITS = uer_pkg::CountBitsDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_start_req,
   input  wire logic                              req_echo_level,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_trigger_level,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic                                   rsp_timed_out,
   output logic      [15:0]                       rsp_pulse_width_us,
   output logic      [15:0]                       rsp_distance_cm,

   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [uer_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  wire logic [uer_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic      [uer_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   uer_pkg::cfg_type      cfg;
   uer_pkg::result_type   result;
   uer_pkg::result_type   rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  accept;

   // The response register frees up when it is empty or being drained this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   uer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer advances by one tick exactly when a request is accepted.
   uer_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .start_req  (req_start_req),
      .echo_level (req_echo_level),
      .cfg        (cfg),
      .result     (result)
   );

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trigger_level  = rsp_ff.trigger_level;
   assign rsp_busy_res       = rsp_ff.busy;
   assign rsp_done_res       = rsp_ff.done;
   assign rsp_timed_out      = rsp_ff.timed_out;
   assign rsp_pulse_width_us = rsp_ff.pulse_width;
   assign rsp_distance_cm    = rsp_ff.distance;

   // A stalled response must hold off new requests.
   `UER_ASSERT(a_stall_blocks_req, clock, reset, (rsp_valid && !rsp_ready) |-> !req_ready)
   // The tick that finishes a measurement already reports idle.
   `UER_ASSERT(a_done_not_busy, clock, reset, (rsp_valid && rsp_done_res) |-> !rsp_busy_res)
   // A timeout is a finished measurement with no width and no distance.
   `UER_ASSERT(a_timeout_zero, clock, reset, (rsp_valid && rsp_timed_out) |-> (rsp_done_res && rsp_pulse_width_us == 16'd0 && rsp_distance_cm == 16'd0))
   // The trigger pin is only driven high inside a measurement.
   `UER_ASSERT(a_trigger_busy, clock, reset, (rsp_valid && rsp_trigger_level) |-> rsp_busy_res)
   // Reset empties the response register.
   `UER_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

`default_nettype wire
